[design/eer_pkg.sv]
// Package for the equal-error-rate threshold search unit.
// Holds state codes, status codes and register indexes; no dependencies.
package eer_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_POS = 2'd1;
  localparam logic [1:0] ST_NO_NEG = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  localparam logic [2:0] REG_COST_MODE = 3'd0;
  localparam logic [2:0] REG_FAR_WEIGHT = 3'd1;
  localparam logic [2:0] REG_SORT_EN = 3'd2;
  localparam logic [2:0] REG_USE_GIVEN = 3'd3;
  localparam logic [2:0] REG_GIVEN_POS = 3'd4;

  localparam int CAP = 100;

  // Sequencer states.
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SORTR = 4'd1;  // read element i
  localparam logic [3:0] S_SORTC = 4'd2;  // read element i-1 and latch the key
  localparam logic [3:0] S_SORTW = 4'd3;  // compare, then shift or place
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_SWR   = 4'd5;  // sweep read
  localparam logic [3:0] S_SWM   = 4'd6;  // multiply
  localparam logic [3:0] S_SWC   = 4'd7;  // cost and compare
  localparam logic [3:0] S_DIVA  = 4'd8;
  localparam logic [3:0] S_DIVB  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_SWN   = 4'd11; // next-score read for threshold

endpackage

[design/eer_hter_threshold_search_unit.sv]
// Equal-error-rate / weighted-error threshold search unit, top level.
// Depends on eer_pkg for state, status and register codes.
//
// Usage: labelled scores stream in on in_* (tdata = score, tuser = label,
// tlast closes a set). Scores are stored one per cycle while in_tready is high,
// in a simple dual-port score/label memory with a registered read port. On the
// last item the block stops accepting, stably sorts the memory in place by
// insertion sort when sorting is enabled, then sweeps the sorted set (read,
// multiply, cost and compare per element), computing cross-multiplied costs
// and keeping the earliest strict minimum. One restoring divider, used twice,
// then gives the Q1.16 rates. One result leaves on out_* and is held until
// taken; the next set is accepted only after the result is taken.
// Reset clears counts and returns to loading; the memory needs no clearing.
// Configuration is written through the cfg_ APB port; the user must write it
// only while the block idles, and the block itself does not enforce this.
module eer_hter_threshold_search_unit #(
  parameter int MAX_ITEMS  = 1024,
  parameter int SCORE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((SCORE_BITS+7)/8)*8-1:0] in_tdata,  // [SCORE_BITS-1:0] score
  input  logic                  in_tuser,            // [0] label
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [SCORE_BITS:0] threshold_doubled, then false_accept(17), false_reject(17), status(2)
  output logic [((SCORE_BITS+37+7)/8)*8-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int CNTW = (CW > 11) ? CW : 11;
  localparam int MW = 2 * CNTW + 1;          // product width
  localparam int KW = MW + 18;               // cost width
  localparam int OUTW = ((SCORE_BITS + 37 + 7) / 8) * 8;
  localparam int SB = SCORE_BITS;

  // Configuration.
  logic        cost_mode_r, sort_en_r, use_given_r;
  logic [15:0] far_weight_r;
  logic [10:0] given_pos_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_mode_r  <= 1'b0;
      far_weight_r <= 16'd256;
      sort_en_r    <= 1'b1;
      use_given_r  <= 1'b0;
      given_pos_r  <= 11'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        eer_pkg::REG_COST_MODE:  cost_mode_r  <= cfg_pwdata[0];
        eer_pkg::REG_FAR_WEIGHT: far_weight_r <= cfg_pwdata[15:0];
        eer_pkg::REG_SORT_EN:    sort_en_r    <= cfg_pwdata[0];
        eer_pkg::REG_USE_GIVEN:  use_given_r  <= cfg_pwdata[0];
        eer_pkg::REG_GIVEN_POS:  given_pos_r  <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      eer_pkg::REG_COST_MODE:  cfg_prdata = {31'd0, cost_mode_r};
      eer_pkg::REG_FAR_WEIGHT: cfg_prdata = {16'd0, far_weight_r};
      eer_pkg::REG_SORT_EN:    cfg_prdata = {31'd0, sort_en_r};
      eer_pkg::REG_USE_GIVEN:  cfg_prdata = {31'd0, use_given_r};
      eer_pkg::REG_GIVEN_POS:  cfg_prdata = {21'd0, given_pos_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // Score/label memory, one write and one registered read per cycle.
  logic [SB:0]   mem [MAX_ITEMS];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [SB:0]   mem_wd, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  logic [3:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, pcnt_r;
  logic [CW-1:0]   i_r, j_r;
  logic [SB:0]     key_r;
  logic [CNTW-1:0] pos_r, neg_r, left_r, passed_r;
  logic [MW-1:0]   a_r, b_r;
  logic [KW-1:0]   best_r, cost_w;
  logic [CNTW-1:0] bacc_r, brej_r;
  logic [CW-1:0]   bidx_r;
  logic signed [SB:0] thr_r;
  logic            found_r, lbl_r;
  logic signed [SB-1:0] cur_r;
  logic [4:0]      dcnt_r;
  logic [CNTW+16:0] rem_r;
  logic [16:0]     quo_r, fa_r;
  logic [1:0]      stat_r;
  logic            ovalid_r;
  logic [OUTW-1:0] odata_r;

  assign in_tready  = (state_r == eer_pkg::S_LOAD) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Cost over the common denominator 256*neg*pos.
  logic [MW-1:0] diff_w;
  assign diff_w = (a_r > b_r) ? a_r - b_r : b_r - a_r;
  always_comb begin
    if (!cost_mode_r) cost_w = KW'({diff_w, 8'd0});
    else cost_w = KW'(far_weight_r) * KW'(a_r) + KW'({b_r, 8'd0});
  end

  logic [KW-1:0] cap_w;
  logic [MW-1:0] np_r;
  assign cap_w = KW'(np_r) * KW'(eer_pkg::CAP * 256);

  // Positive and negative counts of the set that is about to be swept.
  logic [CNTW-1:0] pos_w, neg_w;
  assign pos_w = use_given_r ? CNTW'(given_pos_r) : CNTW'(pcnt_r);
  assign neg_w = (CNTW'(cnt_r) > pos_w) ? CNTW'(cnt_r) - pos_w : '0;

  // One restoring division step: rem holds partial remainder.
  logic [CNTW-1:0] dvs;
  logic [CNTW+16:0] rem_sh;
  logic             dfit;
  assign dvs = (state_r == eer_pkg::S_DIVA) ? neg_r : pos_r;
  assign rem_sh = rem_r;
  assign dfit = rem_sh[CNTW+16:16] >= {1'b0, dvs};

  always_comb begin
    state_nxt = state_r;
    mem_we = 1'b0;
    mem_wa = i_r[AW-1:0];
    mem_wd = key_r;
    mem_ra = i_r[AW-1:0];
    unique case (state_r)
      eer_pkg::S_LOAD: begin
        mem_we = in_acc && (cnt_r < CW'(MAX_ITEMS));
        mem_wa = cnt_r[AW-1:0];
        mem_wd = {in_tuser, in_tdata[SB-1:0]};
        if (in_acc && in_tlast) state_nxt = eer_pkg::S_SORTR;
      end
      eer_pkg::S_SORTR: begin
        mem_ra = i_r[AW-1:0];
        if (!sort_en_r || i_r >= cnt_r) state_nxt = eer_pkg::S_INIT;
        else state_nxt = eer_pkg::S_SORTC;
      end
      eer_pkg::S_SORTC: begin
        mem_ra = AW'(i_r - 1'b1);
        state_nxt = eer_pkg::S_SORTW;
      end
      eer_pkg::S_SORTW: begin
        if (j_r != '0 && $signed(mem_rd_r[SB-1:0]) > $signed(key_r[SB-1:0])) begin
          mem_we = 1'b1;
          mem_wa = j_r[AW-1:0];
          mem_wd = mem_rd_r;
          mem_ra = AW'(j_r - 2'd2);
          state_nxt = eer_pkg::S_SORTW;
        end else begin
          mem_we = 1'b1;
          mem_wa = j_r[AW-1:0];
          mem_wd = key_r;
          mem_ra = AW'(i_r + 1'b1);
          state_nxt = eer_pkg::S_SORTR;
        end
      end
      eer_pkg::S_INIT: begin
        mem_ra = '0;
        state_nxt = eer_pkg::S_SWR;
      end
      eer_pkg::S_SWR: begin
        mem_ra = i_r[AW-1:0];
        if (pos_r == '0 || neg_r == '0 || i_r >= cnt_r) state_nxt = eer_pkg::S_SWN;
        else state_nxt = eer_pkg::S_SWM;
      end
      eer_pkg::S_SWM: state_nxt = eer_pkg::S_SWC;
      eer_pkg::S_SWC: begin
        mem_ra = AW'(i_r + 1'b1);
        state_nxt = eer_pkg::S_SWR;
      end
      eer_pkg::S_SWN: begin
        mem_ra = AW'(bidx_r + 1'b1);
        state_nxt = eer_pkg::S_DIVA;
      end
      eer_pkg::S_DIVA: if (dcnt_r == 5'd17) state_nxt = eer_pkg::S_DIVB;
      eer_pkg::S_DIVB: if (dcnt_r == 5'd17) state_nxt = eer_pkg::S_OUT;
      eer_pkg::S_OUT: state_nxt = eer_pkg::S_LOAD;
      default: state_nxt = eer_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= eer_pkg::S_LOAD;
      cnt_r    <= '0;
      pcnt_r   <= '0;
      ovalid_r <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        eer_pkg::S_LOAD: begin
          if (in_acc && cnt_r < CW'(MAX_ITEMS)) begin
            cnt_r  <= cnt_r + 1'b1;
            pcnt_r <= pcnt_r + CW'(in_tuser);
          end
          i_r <= CW'(1);
        end
        eer_pkg::S_SORTR: ;
        eer_pkg::S_SORTC: begin
          key_r <= mem_rd_r;
          j_r   <= i_r;
        end
        eer_pkg::S_SORTW: begin
          if (j_r != '0 && $signed(mem_rd_r[SB-1:0]) > $signed(key_r[SB-1:0]))
            j_r <= j_r - 1'b1;
          else i_r <= i_r + 1'b1;
        end
        eer_pkg::S_INIT: begin
          pos_r    <= pos_w;
          neg_r    <= neg_w;
          left_r   <= neg_w;
          np_r     <= MW'(neg_w) * MW'(pos_w);
          i_r      <= '0;
          found_r  <= 1'b0;
          bidx_r   <= '0;
          bacc_r   <= '0;
          brej_r   <= '0;
          passed_r <= '0;
        end
        eer_pkg::S_SWR: begin
          if (i_r == '0) begin
            best_r <= '1;
          end else begin
            if (lbl_r) passed_r <= passed_r + 1'b1;
            else if (left_r != '0) left_r <= left_r - 1'b1;
          end
        end
        eer_pkg::S_SWM: begin
          if (i_r == '0) best_r <= cap_w;
          lbl_r <= mem_rd_r[SB];
          if (mem_rd_r[SB]) begin
            a_r <= MW'(left_r) * MW'(pos_r);
            b_r <= MW'(passed_r + 1'b1) * MW'(neg_r);
          end else begin
            a_r <= MW'((left_r != '0) ? left_r - 1'b1 : left_r) * MW'(pos_r);
            b_r <= MW'(passed_r) * MW'(neg_r);
          end
        end
        eer_pkg::S_SWC: begin
          if (cost_w < best_r) begin
            best_r  <= cost_w;
            found_r <= 1'b1;
            bidx_r  <= i_r;
            bacc_r  <= lbl_r ? left_r : ((left_r != '0) ? left_r - 1'b1 : left_r);
            brej_r  <= lbl_r ? passed_r + 1'b1 : passed_r;
          end
          i_r <= i_r + 1'b1;
        end
        eer_pkg::S_SWN: begin
          // Memory output holds the entry read last; read the entry after the best point for the threshold.
          dcnt_r <= '0;
          rem_r  <= {bacc_r, 17'd0} >> 1;
          quo_r  <= '0;
        end
        eer_pkg::S_DIVA, eer_pkg::S_DIVB: begin
          if (dcnt_r == 5'd0 && state_r == eer_pkg::S_DIVA) begin
            cur_r <= $signed(mem_rd_r[SB-1:0]);
          end
          if (dcnt_r == 5'd17) begin
            dcnt_r <= '0;
            if (state_r == eer_pkg::S_DIVA) begin
              fa_r  <= quo_r;
              rem_r <= {brej_r, 17'd0} >> 1;
              quo_r <= '0;
            end else begin
              quo_r <= quo_r;
            end
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
            quo_r  <= {quo_r[15:0], dfit};
            rem_r  <= dfit ? {rem_sh[CNTW+15:16] - dvs, rem_sh[15:0], 1'b0}
                           : {rem_sh[CNTW+15:0], 1'b0};
          end
        end
        eer_pkg::S_OUT: begin
          // A reject count at or above the positive count saturates the rate at one.
          ovalid_r <= 1'b1;
          odata_r  <= OUTW'({stat_r,
                             (stat_r == eer_pkg::ST_OK) ?
                               ((brej_r >= pos_r) ? 17'd65536 : quo_r) : 17'd0,
                             (stat_r == eer_pkg::ST_OK) ? fa_r : 17'd0, thr_r});
          cnt_r    <= '0;
          pcnt_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  // Threshold: low score at best index plus the next one if present.
  logic [SB:0] lo_r;
  always_ff @(posedge clk) begin
    if (state_r == eer_pkg::S_SWR && i_r == '0) lo_r <= mem_rd_r;
    if (state_r == eer_pkg::S_SWC && cost_w < best_r) lo_r <= {1'b0, mem_rd_r[SB-1:0]};
    if (state_r == eer_pkg::S_DIVB && dcnt_r == 5'd0) begin
      if (found_r && (bidx_r + 1'b1 < cnt_r))
        thr_r <= (SB+1)'($signed(lo_r[SB-1:0])) + (SB+1)'(cur_r);
      else
        thr_r <= (SB+1)'($signed(lo_r[SB-1:0])) <<< 1;
      if (pos_r == '0) stat_r <= eer_pkg::ST_NO_POS;
      else if (neg_r == '0) stat_r <= eer_pkg::ST_NO_NEG;
      else if (!found_r) stat_r <= eer_pkg::ST_NONE;
      else stat_r <= eer_pkg::ST_OK;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != eer_pkg::S_LOAD |-> !in_tready)
    else $error("input taken during search");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS))
    else $error("item count overflow");
endmodule
